// ----- rtl/nkps_pkg.sv -----
// shared types, widths and command codes of the nearest-k point selector
`timescale 1ns / 1ps
`default_nettype none
package nkps_pkg;

  localparam int COORD_W = 16;
  localparam int ID_W = 16;
  localparam int RANK_W = 3;
  localparam int ABS_W = 16;
  localparam int SQ_W = 2 * ABS_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int MAX_EMIT = 8;
  localparam int NEAREST_COUNT_DEF = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // chain commands
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_HOLD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHIFT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic [DIST_W-1:0]        distance;
    logic [ID_W-1:0]          id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } slot_t;

  typedef struct packed {
    logic valid;
    logic final_point;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/nkps_dist.sv -----
// three-stage squared distance pipeline from candidate to reference point
`timescale 1ns / 1ps
`default_nettype none
module nkps_dist (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire nkps_pkg::pipe_ctl_t                in_ctl,
  input  wire logic [nkps_pkg::ID_W-1:0]          point_id,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_z,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] ref_x,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] ref_y,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] ref_z,
  output nkps_pkg::pipe_ctl_t                      out_ctl,
  output nkps_pkg::slot_t                          out_point
);
  import nkps_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0] mx, my, mz;

  pipe_ctl_t ctl1, ctl2;
  logic [ABS_W-1:0] ax1, ay1, az1;
  logic [SQ_W-1:0] sx2, sy2, sz2;
  slot_t pt1, pt2, pt3;

  always_comb begin
    dx = {point_x[COORD_W-1], point_x} - {ref_x[COORD_W-1], ref_x};
    dy = {point_y[COORD_W-1], point_y} - {ref_y[COORD_W-1], ref_y};
    dz = {point_z[COORD_W-1], point_z} - {ref_z[COORD_W-1], ref_z};
    mx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    my = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    mz = dz[COORD_W] ? (COORD_W+1)'(-dz) : dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      out_ctl <= '0;
    end else begin
      ctl1 <= in_ctl;
      ctl2 <= ctl1;
      out_ctl <= ctl2;
    end
  end

  // stage 1: axis magnitudes
  always_ff @(posedge clk) begin
    ax1 <= mx[ABS_W-1:0];
    ay1 <= my[ABS_W-1:0];
    az1 <= mz[ABS_W-1:0];
    pt1.valid <= 1'b1;
    pt1.distance <= '0;
    pt1.id <= point_id;
    pt1.x <= point_x;
    pt1.y <= point_y;
    pt1.z <= point_z;
  end

  // stage 2: one multiplier per axis
  always_ff @(posedge clk) begin
    sx2 <= ax1 * ax1;
    sy2 <= ay1 * ay1;
    sz2 <= az1 * az1;
    pt2 <= pt1;
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    pt3 <= '{valid: pt2.valid,
             distance: DIST_W'(sx2) + DIST_W'(sy2) + DIST_W'(sz2),
             id: pt2.id, x: pt2.x, y: pt2.y, z: pt2.z};
  end

  assign out_point = pt3;

endmodule
`default_nettype wire

// ----- rtl/nkps_cell.sv -----
// one ranked slot of the insertion chain
`timescale 1ns / 1ps
`default_nettype none
module nkps_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [nkps_pkg::CMD_W-1:0] cmd,
  input  wire nkps_pkg::slot_t            new_point,
  input  wire nkps_pkg::slot_t            upper,
  input  wire logic                       upper_ins,
  input  wire nkps_pkg::slot_t            lower,
  output nkps_pkg::slot_t                 slot,
  output logic                            ins
);
  import nkps_pkg::*;

  logic valid;
  logic [DIST_W-1:0] distance;
  logic [ID_W-1:0] id;
  logic signed [COORD_W-1:0] x, y, z;

  // new point belongs at or above this slot; ties stay behind
  assign ins = !valid || (new_point.distance < distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_INSERT: begin
          if (upper_ins) begin
            valid <= upper.valid;
          end else if (ins) begin
            valid <= 1'b1;
          end
        end
        CMD_SHIFT: valid <= lower.valid;
        CMD_CLEAR: valid <= 1'b0;
        default: valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INSERT: begin
        if (upper_ins) begin
          distance <= upper.distance;
          id <= upper.id;
          x <= upper.x;
          y <= upper.y;
          z <= upper.z;
        end else if (ins) begin
          distance <= new_point.distance;
          id <= new_point.id;
          x <= new_point.x;
          y <= new_point.y;
          z <= new_point.z;
        end
      end
      CMD_SHIFT: begin
        distance <= lower.distance;
        id <= lower.id;
        x <= lower.x;
        y <= lower.y;
        z <= lower.z;
      end
      default: begin
        distance <= distance;
      end
    endcase
  end

  always_comb begin
    slot.valid = valid;
    slot.distance = distance;
    slot.id = id;
    slot.x = x;
    slot.y = y;
    slot.z = z;
  end

endmodule
`default_nettype wire

// ----- rtl/nearest_k_point_selector_core.sv -----
// top level: register port, distance pipeline, slot chain and result sequencer
// results: a final point passes the distance pipeline, lands in the chain and its
// ranks leave the result register one per cycle, min(NEAREST_COUNT, 8) of them.
// throughput: non-final points are taken every cycle (3-stage distance pipeline
// feeding the slot chain); a final point holds busy while it crosses the pipeline
// and the chain drains. rst is synchronous: slots empty, references 0.
`timescale 1ns / 1ps
`default_nettype none
module nearest_k_point_selector_core #(
  parameter int NEAREST_COUNT = nkps_pkg::NEAREST_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nkps_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [nkps_pkg::DATA_W-1:0]         pwdata,
  output logic [nkps_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready,
  // point command
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [nkps_pkg::ID_W-1:0]           point_id,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [nkps_pkg::COORD_W-1:0] point_z,
  input  wire logic                                final_point,
  // ranked results
  output logic                                     out_valid,
  output logic [nkps_pkg::RANK_W-1:0]              rank,
  output logic                                     filled,
  output logic [nkps_pkg::ID_W-1:0]                out_id,
  output logic signed [nkps_pkg::COORD_W-1:0]      out_x,
  output logic signed [nkps_pkg::COORD_W-1:0]      out_y,
  output logic signed [nkps_pkg::COORD_W-1:0]      out_z,
  output logic                                     last_slot
);
  import nkps_pkg::*;

  localparam int EMIT_COUNT = (NEAREST_COUNT < MAX_EMIT) ? NEAREST_COUNT : MAX_EMIT;
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(EMIT_COUNT - 1);

  // register indexes
  localparam logic [1:0] REG_REF_X = 2'd0;
  localparam logic [1:0] REG_REF_Y = 2'd1;
  localparam logic [1:0] REG_REF_Z = 2'd2;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic signed [COORD_W-1:0] ref_x, ref_y, ref_z;
  logic [1:0] state;
  logic [RANK_W-1:0] emit_cnt;
  logic accept, cfg_write;
  logic [CMD_W-1:0] cmd;
  pipe_ctl_t in_ctl, pipe_ctl;
  slot_t pipe_point;

  slot_t cell_slot [NEAREST_COUNT];
  slot_t upper_slot [NEAREST_COUNT];
  slot_t lower_slot [NEAREST_COUNT];
  logic cell_ins [NEAREST_COUNT];
  logic upper_ins [NEAREST_COUNT];

  // register port: zero-wait, 16-bit registers, upper data bits dropped
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_REF_X: ref_x <= pwdata[COORD_W-1:0];
        REG_REF_Y: ref_y <= pwdata[COORD_W-1:0];
        REG_REF_Z: ref_z <= pwdata[COORD_W-1:0];
        default: ref_x <= ref_x;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_REF_X: prdata = {{(DATA_W-COORD_W){1'b0}}, ref_x};
      REG_REF_Y: prdata = {{(DATA_W-COORD_W){1'b0}}, ref_y};
      REG_REF_Z: prdata = {{(DATA_W-COORD_W){1'b0}}, ref_z};
      default: prdata = '0;
    endcase
  end

  // command transfer
  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_ctl.valid = accept;
  assign in_ctl.final_point = final_point;

  nkps_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (in_ctl),
    .point_id   (point_id),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .ref_x      (ref_x),
    .ref_y      (ref_y),
    .ref_z      (ref_z),
    .out_ctl    (pipe_ctl),
    .out_point  (pipe_point)
  );

  // chain command: insert from the pipeline, shift toward rank 0 while
  // emitting, clear on the last emitted rank
  always_comb begin
    if (state == ST_EMIT) begin
      cmd = (emit_cnt == LAST_RANK) ? CMD_CLEAR : CMD_SHIFT;
    end else if (pipe_ctl.valid) begin
      cmd = CMD_INSERT;
    end else begin
      cmd = CMD_HOLD;
    end
  end

  // neighbor wiring of the slot chain
  for (genvar i = 0; i < NEAREST_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign upper_slot[i] = '0;
      assign upper_ins[i] = 1'b0;
    end else begin : g_mid
      assign upper_slot[i] = cell_slot[i-1];
      assign upper_ins[i] = cell_ins[i-1];
    end
    if (i == NEAREST_COUNT - 1) begin : g_tail
      assign lower_slot[i] = '0;
    end else begin : g_body
      assign lower_slot[i] = cell_slot[i+1];
    end

    nkps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_point (pipe_point),
      .upper     (upper_slot[i]),
      .upper_ins (upper_ins[i]),
      .lower     (lower_slot[i]),
      .slot      (cell_slot[i]),
      .ins       (cell_ins[i])
    );
  end

  // sequencer: wait for the final point to land, then stream rank 0 out
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      emit_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && final_point) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (pipe_ctl.valid && pipe_ctl.final_point) begin
            state <= ST_EMIT;
            emit_cnt <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_cnt == LAST_RANK) begin
            state <= ST_IDLE;
          end
          emit_cnt <= emit_cnt + 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register, one strobe per rank
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    rank <= emit_cnt;
    last_slot <= (emit_cnt == LAST_RANK);
    filled <= cell_slot[0].valid;
    // empty slots read as zero
    out_id <= cell_slot[0].valid ? cell_slot[0].id : '0;
    out_x <= cell_slot[0].valid ? cell_slot[0].x : '0;
    out_y <= cell_slot[0].valid ? cell_slot[0].y : '0;
    out_z <= cell_slot[0].valid ? cell_slot[0].z : '0;
  end

endmodule
`default_nettype wire

// ----- dv/nkps_checker.sv -----
// register map for the stimulus and the predicting checker of the nearest-k point selector
`timescale 1ns / 1ps
package nkps_tb_pkg;

  typedef enum logic [1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_REF_Z = 2'd2,
    REG_SPARE = 2'd3
  } reg_index_e;

endpackage

module nkps_checker #(
  parameter int SLOTS = nkps_pkg::NEAREST_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [nkps_pkg::ADDR_W-1:0]         paddr,
  input  logic [nkps_pkg::DATA_W-1:0]         pwdata,
  input  logic                                start,
  input  logic                                busy,
  input  logic [nkps_pkg::ID_W-1:0]           point_id,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_x,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_y,
  input  logic signed [nkps_pkg::COORD_W-1:0] point_z,
  input  logic                                final_point,
  input  logic                                out_valid,
  input  logic [nkps_pkg::RANK_W-1:0]         rank,
  input  logic                                filled,
  input  logic [nkps_pkg::ID_W-1:0]           out_id,
  input  logic signed [nkps_pkg::COORD_W-1:0] out_x,
  input  logic signed [nkps_pkg::COORD_W-1:0] out_y,
  input  logic signed [nkps_pkg::COORD_W-1:0] out_z,
  input  logic                                last_slot,
  output int                                  fail_count,
  output int                                  pending_results,
  output int                                  results_checked
);
  import nkps_pkg::*;
  import nkps_tb_pkg::*;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic                      filled;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } ranked_slot_t;

  slot_t                     nearest [SLOTS];
  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  ranked_slot_t              awaited [$];
  int                        bad;
  int                        seen;

  function automatic logic [DIST_W-1:0] sq_dist(input logic signed [COORD_W-1:0] x, y, z);
    longint dx, dy, dz;
    dx = x - origin_x;
    dy = y - origin_y;
    dz = z - origin_z;
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  task automatic clear_slots();
    for (int k = 0; k < SLOTS; k++) nearest[k] = '0;
  endtask

  // first empty or strictly farther slot wins, so ties land behind older points
  task automatic take_point(input logic [ID_W-1:0] id,
                            input logic signed [COORD_W-1:0] x, y, z);
    logic [DIST_W-1:0] d;
    bit placed;
    d = sq_dist(x, y, z);
    placed = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (!placed && (!nearest[j].valid || d < nearest[j].distance)) begin
        for (int k = SLOTS - 1; k > j; k--) nearest[k] = nearest[k - 1];
        nearest[j] = '{valid: 1'b1, distance: d, id: id, x: x, y: y, z: z};
        placed = 1'b1;
      end
    end
  endtask

  task automatic emit_ranks();
    ranked_slot_t r;
    int n;
    n = (SLOTS < MAX_EMIT) ? SLOTS : MAX_EMIT;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.rank = RANK_W'(k);
      r.filled = nearest[k].valid;
      if (nearest[k].valid) begin
        r.id = nearest[k].id;
        r.x = nearest[k].x;
        r.y = nearest[k].y;
        r.z = nearest[k].z;
      end
      r.last = (k == n - 1);
      awaited.insert(awaited.size(), r);
    end
    clear_slots();
  endtask

  task automatic flag(input ranked_slot_t want, input ranked_slot_t got, input bit orphan);
    bad++;
    if (bad <= 10) begin
      if (orphan)
        $display("[%0t] unexpected ranked slot: rank %0d filled %0d id %0d (%0d,%0d,%0d) last %0d",
                 $time, got.rank, got.filled, got.id, got.x, got.y, got.z, got.last);
      else begin
        $display("[%0t] mismatch: exp rank %0d filled %0d id %0d (%0d,%0d,%0d) last %0d",
                 $time, want.rank, want.filled, want.id, want.x, want.y, want.z, want.last);
        $display("             got rank %0d filled %0d id %0d (%0d,%0d,%0d) last %0d",
                 got.rank, got.filled, got.id, got.x, got.y, got.z, got.last);
      end
    end
  endtask

  task automatic check_result();
    ranked_slot_t got, want;
    got = '{rank: rank, filled: filled, id: out_id, x: out_x, y: out_y, z: out_z,
            last: last_slot};
    seen++;
    if (awaited.size() == 0) flag('0, got, 1'b1);
    else begin
      want = awaited.pop_front();
      if (got.rank !== want.rank || got.filled !== want.filled || got.id !== want.id ||
          got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.last !== want.last)
        flag(want, got, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_slots();
      origin_x = '0;
      origin_y = '0;
      origin_z = '0;
      awaited.delete();
    end else begin
      if (out_valid) check_result();
      if (psel && penable && pwrite && pready) begin
        case (reg_index_e'(paddr[ADDR_W-1:2]))
          REG_REF_X: origin_x = pwdata[COORD_W-1:0];
          REG_REF_Y: origin_y = pwdata[COORD_W-1:0];
          REG_REF_Z: origin_z = pwdata[COORD_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        take_point(point_id, point_x, point_y, point_z);
        if (final_point) emit_ranks();
      end
    end
    fail_count <= bad;
    pending_results <= awaited.size();
    results_checked <= seen;
  end

endmodule

// ----- dv/tb_nearest_k_point_selector_core.sv -----
// stimulus, clock, reset and verdict for the nearest-k point selector
`timescale 1ns / 1ps
module tb_nearest_k_point_selector_core;
  import nkps_pkg::*;
  import nkps_tb_pkg::*;

  localparam int SLOTS = NEAREST_COUNT_DEF;
  localparam int RANDOM_POINTS = 500;
  // settle margin after the last awaited ranked slot, so this covers anything
  // still inside the pipeline
  localparam int SETTLE_CYCLES = 20;
  // longest legal quiet stretch is a sender gap or a settle, far below this
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      start = 1'b0;
  logic                      busy;
  logic [ID_W-1:0]           point_id = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      final_point = 1'b0;
  logic                      out_valid;
  logic [RANK_W-1:0]         rank;
  logic                      filled;
  logic [ID_W-1:0]           out_id;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      last_slot;

  int fails, pending, checked;

  // stimulus-side view of the reference point, used only to aim candidates
  logic signed [COORD_W-1:0] aim_x = '0, aim_y = '0, aim_z = '0;
  point_t set_hist [$];
  bit     start_held = 1'b0;
  int     burst_left = 0;
  int     points_sent = 0;
  int     sets_sent = 0;
  int     settings_used = 1;
  int     idle_cycles = 0;

  always #5 clk = ~clk;

  nearest_k_point_selector_core #(.NEAREST_COUNT(SLOTS)) DUT (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .point_id, .point_x, .point_y, .point_z, .final_point,
    .out_valid, .rank, .filled, .out_id, .out_x, .out_y, .out_z, .last_slot
  );

  nkps_checker #(.SLOTS(SLOTS)) u_checker (
    .clk, .rst,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .start, .busy, .point_id, .point_x, .point_y, .point_z, .final_point,
    .out_valid, .rank, .filled, .out_id, .out_x, .out_y, .out_z, .last_slot,
    .fail_count(fails), .pending_results(pending), .results_checked(checked)
  );

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic point_t point_at(input int id, x, y, z);
    point_t p;
    p.id = ID_W'(id);
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] corner();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // mix of full-range points, points clustered on the reference, repeats and
  // mirror images of earlier points of the set (equal distances), and corners
  function automatic point_t make_point();
    point_t p, h;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4 || (mode >= 7 && mode < 9 && set_hist.size() == 0)) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else if (mode < 7) begin
      p.x = COORD_W'(int'(aim_x) + int'($urandom_range(0, 127)) - 64);
      p.y = COORD_W'(int'(aim_y) + int'($urandom_range(0, 127)) - 64);
      p.z = COORD_W'(int'(aim_z) + int'($urandom_range(0, 127)) - 64);
    end else if (mode < 9) begin
      h = set_hist[$urandom_range(0, set_hist.size() - 1)];
      p = h;
      if ($urandom_range(0, 1)) begin
        p.x = COORD_W'(2 * int'(aim_x) - int'(h.x));
        p.y = COORD_W'(2 * int'(aim_y) - int'(h.y));
        p.z = COORD_W'(2 * int'(aim_z) - int'(h.z));
      end
    end else begin
      p.x = corner();
      p.y = corner();
      p.z = corner();
    end
    p.id = ID_W'($urandom);
    return p;
  endfunction

  // hold start with the point until busy is low at an edge; between bursts
  // the sender drops start for a random gap
  task automatic send_point(input point_t p, input logic fin);
    int gap;
    start <= 1'b1;
    point_id <= p.id;
    point_x <= p.x;
    point_y <= p.y;
    point_z <= p.z;
    final_point <= fin;
    start_held = 1'b1;
    do @(posedge clk); while (busy);
    points_sent++;
    if (fin) begin
      sets_sent++;
      set_hist.delete();
    end else begin
      set_hist.insert(set_hist.size(), p);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  endtask

  // stop sending, let every ranked slot arrive, then let the pipeline drain
  task automatic settle();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, then access cycle; psel drops after so writes never abut
  task automatic write_reg(input reg_index_e idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_REF_X: aim_x = value[COORD_W-1:0];
      REG_REF_Y: aim_y = value[COORD_W-1:0];
      REG_REF_Z: aim_z = value[COORD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] origin_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // new reference point; upper data bits are noise the block must drop
  task automatic reconfigure();
    reg_index_e idx;
    for (int i = 0; i < 3; i++) begin
      idx = reg_index_e'(i);
      if ($urandom_range(0, 3) != 0) write_reg(idx, {16'($urandom), origin_value()});
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
    settings_used++;
  endtask

  initial begin
    int set_len;
    int random_sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // lone point at the far corner: one filled slot, the rest empty
    send_point(point_at(16'hFFFF, -32768, -32768, -32768), 1'b1);

    // reference at the origin: ties at distance 1, zero distance twice,
    // far corners that get pushed out once more than eight points arrive,
    // and a final point that ties with earlier ones and goes behind them
    send_point(point_at(0, 1, 0, 0), 1'b0);
    send_point(point_at(1, 0, 1, 0), 1'b0);
    send_point(point_at(2, 0, 0, -1), 1'b0);
    send_point(point_at(3, 32767, 32767, 32767), 1'b0);
    send_point(point_at(4, 0, 0, 0), 1'b0);
    send_point(point_at(5, 2, 0, 0), 1'b0);
    send_point(point_at(6, 0, 0, 0), 1'b0);
    send_point(point_at(7, -32768, 0, 0), 1'b0);
    send_point(point_at(8, 100, 100, 100), 1'b0);
    send_point(point_at(9, 1, 1, 0), 1'b0);
    send_point(point_at(10, 0, 0, 1), 1'b1);
    settle();

    // extreme reference, junk in the upper data bits, and a write to the
    // unused register slot that must change nothing
    write_reg(REG_REF_X, 32'h5A5A_7FFF);
    write_reg(REG_REF_Y, 32'hFFFF_8000);
    write_reg(REG_REF_Z, 32'h0001_7FFF);
    write_reg(REG_SPARE, 32'h1234_0042);
    settings_used++;

    // eight points fill every slot, then a final point at the largest
    // possible distance beats none of them and is dropped
    send_point(point_at(16, 32767, -32768, 32767), 1'b0);
    send_point(point_at(17, 32766, -32768, 32767), 1'b0);
    send_point(point_at(18, 32767, -32767, 32767), 1'b0);
    send_point(point_at(19, 0, 0, 0), 1'b0);
    send_point(point_at(20, 32767, -32768, 32766), 1'b0);
    send_point(point_at(21, -1, -1, -1), 1'b0);
    send_point(point_at(22, 100, -100, 100), 1'b0);
    send_point(point_at(23, 32000, -32000, 32000), 1'b0);
    send_point(point_at(24, -32768, 32767, -32768), 1'b1);

    // random sets: mostly short, some long enough to overflow the slots;
    // every few sets the bus goes quiet and the reference moves
    random_sent = 0;
    while (random_sent < RANDOM_POINTS) begin
      set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < set_len; i++) send_point(make_point(), i == set_len - 1);
      random_sent += set_len;
      if ($urandom_range(0, 4) == 0) begin
        settle();
        reconfigure();
      end
    end
    settle();

    $display("covered %0d points in %0d sets under %0d reference settings",
             points_sent, sets_sent, settings_used);
    $display("checked %0d ranked slots, %0d failures, %0d still awaited",
             checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nkps_pkg.sv
rtl/nkps_dist.sv
rtl/nkps_cell.sv
rtl/nearest_k_point_selector_core.sv
dv/nkps_checker.sv
dv/tb_nearest_k_point_selector_core.sv
